FILE: src/thmap_pkg.sv
// Shared constants, types and the divider step for the tiled heightmap address map.
// No dependencies.
package thmap_pkg;

    localparam int CELL_SPAN_W  = 9;
    localparam int TILE_COUNT_W = 7;
    localparam int COORD_W      = 14;
    localparam int HEIGHT_W     = 32;
    localparam int TILE_W       = 6;
    localparam int LOCAL_W      = 9;

    localparam int MAX_TILES    = 64;
    localparam int MAX_SPAN     = 256;
    localparam int SPAN_RESET   = 32;
    localparam int COUNT_RESET  = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SPAN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT = 1'd1;
    localparam int CFG_DATA_W = CELL_SPAN_W;

    // Divider: quotient bits resolved per pipeline stage
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = (COORD_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int DVD_W          = DIV_STAGES * BITS_PER_STAGE;
    localparam int REM_W          = CELL_SPAN_W;

    // Register stages in the whole pipeline: divider stages plus the result stage
    localparam int NUM_STAGES = DIV_STAGES + 1;

    typedef struct packed {
        logic [REM_W-1:0]          rem;
        logic [BITS_PER_STAGE-1:0] qbits;
    } div_step_t;

    // Restoring division over BITS_PER_STAGE dividend bits, MSB first.
    function automatic div_step_t div_step(
        input logic [REM_W-1:0]          rem_in,
        input logic [BITS_PER_STAGE-1:0] bits,
        input logic [CELL_SPAN_W-1:0]    span
    );
        logic [REM_W:0]   trial;
        logic [REM_W-1:0] rem;
        div_step_t        res;
        rem = rem_in;
        res.qbits = '0;
        for (int i = BITS_PER_STAGE - 1; i >= 0; i--) begin
            trial = {rem, bits[i]};
            if (trial >= {1'b0, span})
            begin
                trial = trial - {1'b0, span};
                res.qbits[i] = 1'b1;
            end
            rem = trial[REM_W-1:0];
        end
        res.rem = rem;
        return res;
    endfunction

endpackage

FILE: src/thmap_axis_div.sv
// Pipelined restoring divider for one coordinate axis: coord / span and coord % span.
// Depends on thmap_pkg; stage advance is driven by the top level.
module thmap_axis_div
    import thmap_pkg::*;
(
    input  logic                   clk,
    input  logic [DIV_STAGES-1:0]  load,
    input  logic [COORD_W-1:0]     coord,
    input  logic [CELL_SPAN_W-1:0] span,
    output logic [DVD_W-1:0]       quot,
    output logic [REM_W-1:0]       rem,
    output logic [DVD_W-1:0]       dvd
);

    logic [DVD_W-1:0] dvd_reg  [DIV_STAGES];
    logic [DVD_W-1:0] quot_reg [DIV_STAGES];
    logic [REM_W-1:0] rem_reg  [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic [DVD_W-1:0] dvd_in;
            logic [DVD_W-1:0] quot_in;
            logic [REM_W-1:0] rem_in;
            div_step_t        step;

            if (k == 0)
            begin : g_first
                assign dvd_in  = DVD_W'(coord);
                assign quot_in = '0;
                assign rem_in  = '0;
            end
            else
            begin : g_next
                assign dvd_in  = dvd_reg[k-1];
                assign quot_in = quot_reg[k-1];
                assign rem_in  = rem_reg[k-1];
            end

            assign step = div_step(rem_in,
                                   dvd_in[DVD_W-1-k*BITS_PER_STAGE -: BITS_PER_STAGE], span);

            always_ff @(posedge clk)
            begin
                if (load[k])
                begin
                    dvd_reg[k]  <= dvd_in;
                    quot_reg[k] <= {quot_in[DVD_W-BITS_PER_STAGE-1:0], step.qbits};
                    rem_reg[k]  <= step.rem;
                end
            end
        end
    endgenerate

    assign quot = quot_reg[DIV_STAGES-1];
    assign rem  = rem_reg[DIV_STAGES-1];
    assign dvd  = dvd_reg[DIV_STAGES-1];

endmodule

FILE: src/tiled_heightmap_address_map.sv
// Tiled heightmap address map: top level with config registers, pipeline control and seam logic.
// Depends on thmap_pkg and thmap_axis_div.
//
//  Channel | Signals                                   | Dir | Handshake
//  --------+-------------------------------------------+-----+------------------
//  config  | cfg_we, cfg_index, cfg_data               | in  | write when cfg_we
//  input   | coord_x, coord_y, height_in               | in  | in_valid/in_ready
//  result  | tile_x..out_of_range, height_out          | out | out_valid/out_ready
//
//  One transaction per cycle sustained while out_ready is held high: four divider
//  stages resolve four quotient bits each, then one stage applies seam and range checks.
//  Reset clears the valid bits and loads span 32 and tile count 8; no clearing pass.
//  Each stage advances when it is empty or the stage after it advances, so bubbles
//  collapse and input is taken while a finished result waits on out_ready.
module tiled_heightmap_address_map
    import thmap_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COORD_W-1:0]      coord_x,
    input  logic [COORD_W-1:0]      coord_y,
    input  logic [HEIGHT_W-1:0]     height_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [TILE_W-1:0]       tile_x,
    output logic [TILE_W-1:0]       tile_y,
    output logic [LOCAL_W-1:0]      local_x,
    output logic [LOCAL_W-1:0]      local_y,
    output logic                    copy_right,
    output logic                    copy_below,
    output logic                    copy_corner,
    output logic                    out_of_range,
    output logic [HEIGHT_W-1:0]     height_out
);

    // Effective (clamped) configuration
    logic [CELL_SPAN_W-1:0]  span_reg, span_next;
    logic [TILE_COUNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        span_next  = span_reg;
        count_next = count_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CELL_SPAN:
                begin
                    if (cfg_data == '0)
                        span_next = CELL_SPAN_W'(1);
                    else if (cfg_data > CELL_SPAN_W'(MAX_SPAN))
                        span_next = CELL_SPAN_W'(MAX_SPAN);
                    else
                        span_next = cfg_data;
                end
                REG_TILE_COUNT:
                begin
                    if (cfg_data[TILE_COUNT_W-1:0] == '0)
                        count_next = TILE_COUNT_W'(1);
                    else if (cfg_data[TILE_COUNT_W-1:0] > TILE_COUNT_W'(MAX_TILES))
                        count_next = TILE_COUNT_W'(MAX_TILES);
                    else
                        count_next = cfg_data[TILE_COUNT_W-1:0];
                end
                default:
                begin
                    span_next  = span_reg;
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg  <= CELL_SPAN_W'(SPAN_RESET);
            count_reg <= TILE_COUNT_W'(COUNT_RESET);
        end
        else
        begin
            span_reg  <= span_next;
            count_reg <= count_next;
        end
    end

    // Pipeline control
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] load;

    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
            load[k] = !valid_reg[k] || load[k+1];
    end

    always_comb
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (!load[k])
                valid_next[k] = valid_reg[k];
            else if (k == 0)
                valid_next[k] = in_valid;
            else
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // Height word rides along the divider stages
    logic [HEIGHT_W-1:0] hgt_reg [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (load[k])
                hgt_reg[k] <= (k == 0) ? height_in : hgt_reg[(k == 0) ? 0 : k-1];
        end
    end

    // Dividers
    logic [DVD_W-1:0] qx, qy, dx, dy;
    logic [REM_W-1:0] rx, ry;

    thmap_axis_div u_div_x (
        .clk   (clk),
        .load  (load[DIV_STAGES-1:0]),
        .coord (coord_x),
        .span  (span_reg),
        .quot  (qx),
        .rem   (rx),
        .dvd   (dx)
    );

    thmap_axis_div u_div_y (
        .clk   (clk),
        .load  (load[DIV_STAGES-1:0]),
        .coord (coord_y),
        .span  (span_reg),
        .quot  (qy),
        .rem   (ry),
        .dvd   (dy)
    );

    // Seam adjust: a nonzero coordinate on a seam goes to the earlier tile at offset span
    logic             seam_x, seam_y;
    logic [DVD_W-1:0] tx, ty, cnt_ext;
    logic [REM_W-1:0] ox, oy;
    logic             oor, right, below;

    always_comb
    begin
        seam_x  = (rx == '0) && (|dx);
        seam_y  = (ry == '0) && (|dy);
        tx      = seam_x ? qx - DVD_W'(1) : qx;
        ty      = seam_y ? qy - DVD_W'(1) : qy;
        ox      = seam_x ? span_reg : rx;
        oy      = seam_y ? span_reg : ry;
        cnt_ext = DVD_W'(count_reg);
        oor     = (tx >= cnt_ext) || (ty >= cnt_ext);
        right   = (ox == span_reg) && (tx < cnt_ext - DVD_W'(1));
        below   = (oy == span_reg) && (ty < cnt_ext - DVD_W'(1));
    end

    logic [TILE_W-1:0]   tile_x_reg, tile_y_reg;
    logic [LOCAL_W-1:0]  local_x_reg, local_y_reg;
    logic                right_reg, below_reg, corner_reg, oor_reg;
    logic [HEIGHT_W-1:0] height_reg;

    always_ff @(posedge clk)
    begin
        if (load[NUM_STAGES-1])
        begin
            tile_x_reg  <= oor ? '0 : tx[TILE_W-1:0];
            tile_y_reg  <= oor ? '0 : ty[TILE_W-1:0];
            local_x_reg <= oor ? '0 : LOCAL_W'(ox);
            local_y_reg <= oor ? '0 : LOCAL_W'(oy);
            right_reg   <= !oor && right;
            below_reg   <= !oor && below;
            corner_reg  <= !oor && right && below;
            oor_reg     <= oor;
            height_reg  <= hgt_reg[DIV_STAGES-1];
        end
    end

    assign tile_x       = tile_x_reg;
    assign tile_y       = tile_y_reg;
    assign local_x      = local_x_reg;
    assign local_y      = local_y_reg;
    assign copy_right   = right_reg;
    assign copy_below   = below_reg;
    assign copy_corner  = corner_reg;
    assign out_of_range = oor_reg;
    assign height_out   = height_reg;

    // Checks
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> tile_x == '0 && tile_y == '0 && local_x == '0
            && local_y == '0 && !copy_right && !copy_below)
        else $error("out_of_range result carries nonzero address fields");

    a_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && copy_corner |-> copy_right && copy_below)
        else $error("corner copy without right and below copies");

    a_local_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_of_range |-> local_x <= LOCAL_W'(span_reg)
            && local_y <= LOCAL_W'(span_reg))
        else $error("local offset exceeds span");

    a_tile_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_of_range |-> TILE_COUNT_W'(tile_x) < count_reg
            && TILE_COUNT_W'(tile_y) < count_reg)
        else $error("tile index beyond tile count without range flag");

    a_right_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && copy_right |-> local_x == LOCAL_W'(span_reg))
        else $error("right copy off the right seam");

endmodule
